// ----- sv/iirdf1_pkg.sv -----
// Package for the direct form I IIR filter: widths, operation codes,
// the per-cell control struct and small helper functions.
// No dependencies; used by iirdf1_cell and iir_direct_form_one_filter.
package iirdf1_pkg;

    localparam int MAX_ORDER = 8;
    localparam int SLOT_W    = $clog2(MAX_ORDER);
    localparam int ORDER_W   = 4;
    localparam int IDX_W     = 4;
    localparam int DATA_W    = 24;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = PROD_W + $clog2(2 * MAX_ORDER + 1);
    localparam int FRAC_SH   = 20;
    localparam int CNT_LAST  = MAX_ORDER + 2;
    localparam int CNT_W     = $clog2(CNT_LAST + 1);

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_WR_NUM = 2'd1;
    localparam logic [1:0] OP_WR_DEN = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    typedef struct packed {
        logic wr_b;
        logic wr_a;
        logic mul_en;
        logic add_en;
        logic active;
    } cell_ctl_t;

    function automatic logic [ORDER_W-1:0] eff_order(input logic [ORDER_W-1:0] ord);
        logic [ORDER_W-1:0] n;
        n = ord;
        if (n == '0) begin
            n = ORDER_W'(1);
        end
        if (n > ORDER_W'(MAX_ORDER)) begin
            n = ORDER_W'(MAX_ORDER);
        end
        return n;
    endfunction

    // Reduces a slot number modulo the order by repeated subtraction.
    function automatic logic [SLOT_W-1:0] slot_mod(input logic [SLOT_W-1:0] p,
                                                   input logic [ORDER_W-1:0] n);
        logic [ORDER_W-1:0] r;
        r = ORDER_W'(p);
        for (int i = 0; i < MAX_ORDER; i++) begin
            if (r >= n) begin
                r = r - n;
            end
        end
        return r[SLOT_W-1:0];
    endfunction

endpackage

// ----- sv/iirdf1_cell.sv -----
// One tap cell of the filter: holds a numerator and a denominator coefficient,
// forms its two products and adds b*hx - a*hy into the partial sum down the row.
// Depends on iirdf1_pkg.
module iirdf1_cell (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  iirdf1_pkg::cell_ctl_t                   ctl,
    input  logic signed [iirdf1_pkg::DATA_W-1:0]    wdata,
    input  logic signed [iirdf1_pkg::DATA_W-1:0]    hx,
    input  logic signed [iirdf1_pkg::DATA_W-1:0]    hy,
    input  logic signed [iirdf1_pkg::ACC_W-1:0]     sum_in,
    output logic signed [iirdf1_pkg::ACC_W-1:0]     sum_out,
    output logic signed [iirdf1_pkg::DATA_W-1:0]    b_coef
);

    logic signed [iirdf1_pkg::DATA_W-1:0] b_reg;
    logic signed [iirdf1_pkg::DATA_W-1:0] a_reg;
    logic signed [iirdf1_pkg::PROD_W-1:0] pb_reg;
    logic signed [iirdf1_pkg::PROD_W-1:0] pa_reg;
    logic signed [iirdf1_pkg::ACC_W-1:0]  sum_reg;
    logic signed [iirdf1_pkg::ACC_W-1:0]  sum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg <= '0;
            a_reg <= '0;
        end
        else
        begin
            if (ctl.wr_b)
            begin
                b_reg <= wdata;
            end
            if (ctl.wr_a)
            begin
                a_reg <= wdata;
            end
        end
    end

    always_comb
    begin
        if (ctl.active)
        begin
            sum_next = sum_in + iirdf1_pkg::ACC_W'(pb_reg) - iirdf1_pkg::ACC_W'(pa_reg);
        end
        else
        begin
            sum_next = sum_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            pb_reg <= hx * b_reg;
            pa_reg <= hy * a_reg;
        end
        if (ctl.add_en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum_out = sum_reg;
    assign b_coef  = b_reg;

endmodule

// ----- sv/iir_direct_form_one_filter.sv -----
// Top level of the direct form I IIR filter: stream ports, order register,
// circular histories, sequencer, row of tap cells and output rounding.
// Depends on iirdf1_pkg and iirdf1_cell.
//
// Channel  Direction  Handshake              Payload
// s        in         s_tvalid / s_tready    s_tdata, s_tuser
// m        out        m_tvalid / m_tready    m_tdata, m_tuser
// cfg      in         cfg_valid / cfg_ready  cfg_data (filter order)
//
// A sample transaction loads the output register once the row has finished, and the
// next transaction can be accepted in the cycle after: history reads feed the row of 8 tap
// cells, the partial sum walks the row one cell per cycle, and a final step rounds and saturates.
// Coefficient writes and history clears complete in the cycle they are accepted.
// Reset zeroes the coefficients and histories and sets the order to one.
// A result waits in the output register while the next transaction is accepted;
// the rounding step holds until that register is free.
module iir_direct_form_one_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // coeff_index [3:0], data_value [27:4], zero [31:28]
    input  logic [1:0]  s_tuser,   // opcode [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // sample_out [23:0]
    output logic [0:0]  m_tuser,   // saturated [0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data   // filter_order [3:0]
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    localparam int DW  = iirdf1_pkg::DATA_W;
    localparam int AW  = iirdf1_pkg::ACC_W;
    localparam int MO  = iirdf1_pkg::MAX_ORDER;
    localparam int SW  = iirdf1_pkg::SLOT_W;
    localparam int OW  = iirdf1_pkg::ORDER_W;
    localparam int CW  = iirdf1_pkg::CNT_W;
    localparam int YW  = AW - iirdf1_pkg::FRAC_SH;

    logic                      state_reg;
    logic [CW-1:0]             cnt_reg;
    logic [OW-1:0]             order_reg;
    logic [SW-1:0]             slot_reg;
    logic [SW-1:0]             k_reg;
    logic [SW-1:0]             pe_reg;
    logic signed [DW-1:0]      x_reg;
    logic signed [DW-1:0]      hx_reg;
    logic signed [DW-1:0]      hy_reg;
    logic signed [AW-1:0]      seed_reg;
    logic signed [DW-1:0]      b_top_reg;
    logic signed [DW-1:0]      xh_reg [MO];
    logic signed [DW-1:0]      yh_reg [MO];
    logic                      out_valid_reg;
    logic signed [DW-1:0]      out_data_reg;
    logic                      out_sat_reg;

    logic [1:0]                opcode;
    logic [iirdf1_pkg::IDX_W-1:0] coeff_index;
    logic signed [DW-1:0]      data_value;
    logic                      in_go;
    logic                      fin_go;
    logic [OW-1:0]             n_eff;
    logic [SW-1:0]             p_mod;
    logic [SW-1:0]             k_next;
    logic [SW-1:0]             slot_next;
    logic signed [DW-1:0]      b_n;
    logic signed [iirdf1_pkg::PROD_W-1:0] seed_prod;
    logic signed [AW-1:0]      rnd;
    logic signed [YW-1:0]      y_wide;
    logic signed [DW-1:0]      y_sat;
    logic                      y_clip;

    iirdf1_pkg::cell_ctl_t     ctl [MO];
    logic signed [AW-1:0]      sum_w [MO+1];
    logic signed [DW-1:0]      cell_b [MO];

    assign opcode      = s_tuser;
    assign coeff_index = s_tdata[3:0];
    assign data_value  = s_tdata[27:4];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_go     = s_tvalid && s_tready;
    assign fin_go    = (state_reg == ST_RUN) && (cnt_reg == CW'(iirdf1_pkg::CNT_LAST))
                       && (!out_valid_reg || m_tready);

    assign n_eff     = iirdf1_pkg::eff_order(order_reg);
    assign p_mod     = iirdf1_pkg::slot_mod(slot_reg, n_eff);
    assign k_next    = (OW'(k_reg) + OW'(1) == n_eff) ? '0 : k_reg + SW'(1);
    assign slot_next = (OW'(pe_reg) + OW'(1) == n_eff) ? '0 : pe_reg + SW'(1);
    assign b_n       = (n_eff == OW'(MO)) ? b_top_reg : cell_b[n_eff[SW-1:0]];
    assign seed_prod = x_reg * b_n;

    always_comb
    begin
        rnd    = sum_w[MO] + AW'(1 << (iirdf1_pkg::FRAC_SH - 1));
        y_wide = rnd[AW-1:iirdf1_pkg::FRAC_SH];
        if (y_wide > YW'(signed'(DW'({1'b0, {(DW-1){1'b1}}}))))
        begin
            y_sat  = {1'b0, {(DW-1){1'b1}}};
            y_clip = 1'b1;
        end
        else if (y_wide < YW'(signed'(DW'({1'b1, {(DW-1){1'b0}}}))))
        begin
            y_sat  = {1'b1, {(DW-1){1'b0}}};
            y_clip = 1'b1;
        end
        else
        begin
            y_sat  = y_wide[DW-1:0];
            y_clip = 1'b0;
        end
    end

    always_comb
    begin
        for (int i = 0; i < MO; i++)
        begin
            ctl[i].wr_b   = in_go && (opcode == iirdf1_pkg::OP_WR_NUM)
                            && (coeff_index == iirdf1_pkg::IDX_W'(i));
            ctl[i].wr_a   = in_go && (opcode == iirdf1_pkg::OP_WR_DEN)
                            && (coeff_index == iirdf1_pkg::IDX_W'(i));
            ctl[i].mul_en = (state_reg == ST_RUN) && (cnt_reg == CW'(i + 1));
            ctl[i].add_en = (state_reg == ST_RUN) && (cnt_reg == CW'(i + 2));
            ctl[i].active = (OW'(i) < n_eff);
        end
    end

    assign sum_w[0] = seed_reg;

    for (genvar g = 0; g < MO; g++)
    begin : g_cell
        iirdf1_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl[g]),
            .wdata   (data_value),
            .hx      (hx_reg),
            .hy      (hy_reg),
            .sum_in  (sum_w[g]),
            .sum_out (sum_w[g+1]),
            .b_coef  (cell_b[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            order_reg     <= OW'(1);
            slot_reg      <= '0;
            b_top_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MO; i++)
            begin
                xh_reg[i] <= '0;
                yh_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                order_reg <= cfg_data;
            end
            if (m_tvalid && m_tready && !fin_go)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_go)
                    begin
                        case (opcode)
                            iirdf1_pkg::OP_SAMPLE:
                            begin
                                state_reg <= ST_RUN;
                                cnt_reg   <= '0;
                            end
                            iirdf1_pkg::OP_WR_NUM:
                            begin
                                if (coeff_index == iirdf1_pkg::IDX_W'(MO))
                                begin
                                    b_top_reg <= data_value;
                                end
                            end
                            iirdf1_pkg::OP_CLEAR:
                            begin
                                slot_reg <= '0;
                                for (int i = 0; i < MO; i++)
                                begin
                                    xh_reg[i] <= '0;
                                    yh_reg[i] <= '0;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_RUN:
                begin
                    if (cnt_reg != CW'(iirdf1_pkg::CNT_LAST))
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                    else if (fin_go)
                    begin
                        state_reg      <= ST_IDLE;
                        out_valid_reg  <= 1'b1;
                        xh_reg[pe_reg] <= x_reg;
                        yh_reg[pe_reg] <= y_sat;
                        slot_reg       <= slot_next;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_go && (opcode == iirdf1_pkg::OP_SAMPLE))
        begin
            x_reg  <= data_value;
            k_reg  <= p_mod;
            pe_reg <= p_mod;
        end
        if ((state_reg == ST_RUN) && (cnt_reg < CW'(MO)))
        begin
            hx_reg <= xh_reg[k_reg];
            hy_reg <= yh_reg[k_reg];
            k_reg  <= k_next;
        end
        if ((state_reg == ST_RUN) && (cnt_reg == '0))
        begin
            seed_reg <= AW'(seed_prod);
        end
        if (fin_go)
        begin
            out_data_reg <= y_sat;
            out_sat_reg  <= y_clip;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_sat_reg;

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for iir_direct_form_one_filter: a queue-fed stream driver,
// a clocked monitor and a bit-exact direct form I predictor with a result scoreboard.
// Depends on iirdf1_pkg and the filter RTL.
module tb;

    localparam int HALF_PERIOD = 2;
    localparam int SETTLE      = 16;
    localparam int WD_LIMIT    = 3000;
    localparam int ITEM_GOAL   = 1100;

    typedef enum logic [1:0] {STEP_XFER, STEP_ORDER, STEP_DRAIN} step_kind_e;

    typedef struct packed {
        step_kind_e  kind;
        logic [1:0]  op;
        logic [3:0]  idx;
        logic [23:0] data;
        logic [3:0]  order;
    } step_t;

    typedef struct packed {
        logic [23:0] sample;
        logic        sat;
    } filt_res_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;   // coeff_index [3:0], data_value [27:4], zero [31:28]
    logic [1:0]  s_tuser   = '0;   // opcode [1:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;          // sample_out [23:0]
    logic [0:0]  m_tuser;          // saturated [0]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_data  = '0;   // filter_order [3:0]

    step_t     stim_q[$];
    filt_res_t expected_q[$];

    logic signed [23:0] x_hist [iirdf1_pkg::MAX_ORDER];
    logic signed [23:0] y_hist [iirdf1_pkg::MAX_ORDER];
    logic signed [23:0] num_coef [iirdf1_pkg::MAX_ORDER+1];
    logic signed [23:0] den_coef [iirdf1_pkg::MAX_ORDER];
    int unsigned        next_slot;
    logic [3:0]         order_reg;

    logic s_taken   = 1'b0;
    logic cfg_taken = 1'b0;
    int   quiet     = 0;
    int   stalled   = 0;
    int   errors    = 0;
    int   sent      = 0;
    int   received  = 0;
    int   n_items   = 0;

    iir_direct_form_one_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic int unsigned taps_in_use(input logic [3:0] ord);
        if (ord == 4'd0)
        begin
            return 1;
        end
        if (ord > iirdf1_pkg::MAX_ORDER)
        begin
            return iirdf1_pkg::MAX_ORDER;
        end
        return ord;
    endfunction

    function automatic void clear_history();
        foreach (x_hist[i])
        begin
            x_hist[i] = '0;
            y_hist[i] = '0;
        end
        next_slot = 0;
    endfunction

    function automatic filt_res_t run_filter(input logic signed [23:0] x);
        int unsigned n;
        int unsigned p;
        int unsigned k;
        longint      acc;
        longint      y;
        filt_res_t   r;
        n   = taps_in_use(order_reg);
        p   = next_slot % n;
        acc = 0;
        for (int i = 0; i < n; i++)
        begin
            k   = (p + i) % n;
            acc = acc + longint'(x_hist[k]) * longint'(num_coef[i]);
            acc = acc - longint'(y_hist[k]) * longint'(den_coef[i]);
        end
        acc = acc + longint'(x) * longint'(num_coef[n]);
        y   = (acc + 64'sd524288) >>> 20;
        r.sat = 1'b0;
        if (y > 64'sd8388607)
        begin
            y     = 64'sd8388607;
            r.sat = 1'b1;
        end
        else if (y < -64'sd8388608)
        begin
            y     = -64'sd8388608;
            r.sat = 1'b1;
        end
        r.sample  = y[23:0];
        x_hist[p] = x;
        y_hist[p] = y[23:0];
        next_slot = (p + 1) % n;
        return r;
    endfunction

    function automatic void apply_transaction(input logic [1:0] op, input logic [3:0] idx,
                                              input logic [23:0] data);
        case (op)
            iirdf1_pkg::OP_WR_NUM:
            begin
                if (idx <= iirdf1_pkg::MAX_ORDER)
                begin
                    num_coef[idx] = data;
                end
            end
            iirdf1_pkg::OP_WR_DEN:
            begin
                if (idx < iirdf1_pkg::MAX_ORDER)
                begin
                    den_coef[idx] = data;
                end
            end
            iirdf1_pkg::OP_CLEAR:
            begin
                clear_history();
            end
            default:
            begin
                expected_q.push_back(run_filter(data));
            end
        endcase
    endfunction

    function automatic void add_xfer(input logic [1:0] op, input logic [3:0] idx,
                                     input logic [23:0] data);
        step_t st;
        st.kind  = STEP_XFER;
        st.op    = op;
        st.idx   = idx;
        st.data  = data;
        st.order = '0;
        stim_q.push_back(st);
        if (op == iirdf1_pkg::OP_SAMPLE || op == iirdf1_pkg::OP_CLEAR
            || (op == iirdf1_pkg::OP_WR_NUM && idx <= iirdf1_pkg::MAX_ORDER)
            || (op == iirdf1_pkg::OP_WR_DEN && idx < iirdf1_pkg::MAX_ORDER))
        begin
            n_items++;
        end
    endfunction

    function automatic void add_control(input step_kind_e kind, input logic [3:0] ord);
        step_t st;
        st       = '0;
        st.kind  = kind;
        st.order = ord;
        stim_q.push_back(st);
    endfunction

    function automatic logic [23:0] rand_value();
        logic signed [23:0] v;
        v = 24'($urandom());
        if ($urandom_range(0, 2) != 0)
        begin
            v = v >>> $urandom_range(2, 9);
        end
        return v;
    endfunction

    always @(posedge clk)
    begin
        filt_res_t want;
        logic      s_fire;
        logic      c_fire;
        logic      m_fire;
        if (rst_n)
        begin
            s_fire = s_tvalid && s_tready;
            c_fire = cfg_valid && cfg_ready;
            m_fire = m_tvalid && m_tready;
            if (c_fire)
            begin
                order_reg = cfg_data;
            end
            if (s_fire)
            begin
                apply_transaction(s_tuser, s_tdata[3:0], s_tdata[27:4]);
            end
            if (m_fire)
            begin
                received++;
                if (expected_q.size() == 0)
                begin
                    $error("sample_out: no result expected, got %0d", $signed(m_tdata));
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (m_tdata !== want.sample)
                    begin
                        $error("sample_out: expected %0d, got %0d",
                               $signed(want.sample), $signed(m_tdata));
                        errors++;
                    end
                    if (m_tuser[0] !== want.sat)
                    begin
                        $error("saturated: expected %0b, got %0b", want.sat, m_tuser[0]);
                        errors++;
                    end
                end
            end
            s_taken   <= s_fire;
            cfg_taken <= c_fire;
            if (expected_q.size() != 0 || s_tvalid)
            begin
                quiet = 0;
            end
            else if (quiet < SETTLE)
            begin
                quiet++;
            end
            if (s_fire || c_fire || m_fire)
            begin
                stalled = 0;
            end
            else
            begin
                stalled++;
            end
            if (stalled >= WD_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        step_t st;
        logic  s_next;
        logic  c_next;
        logic  tx_calm;
        logic  rx_calm;
        if (rst_n)
        begin
            tx_calm = (sent >= 300 && sent < 550);
            rx_calm = (received >= 250 && received < 450);
            m_tready <= rx_calm || ($urandom_range(0, 99) >= 14);
            if (!((s_tvalid && !s_taken) || (cfg_valid && !cfg_taken)))
            begin
                s_next = 1'b0;
                c_next = 1'b0;
                if (stim_q.size() != 0)
                begin
                    st = stim_q[0];
                    case (st.kind)
                        STEP_DRAIN:
                        begin
                            if (expected_q.size() == 0)
                            begin
                                void'(stim_q.pop_front());
                            end
                        end
                        STEP_ORDER:
                        begin
                            if (quiet >= SETTLE)
                            begin
                                c_next = 1'b1;
                                cfg_data <= st.order;
                                void'(stim_q.pop_front());
                            end
                        end
                        default:
                        begin
                            if (tx_calm || $urandom_range(0, 99) >= 14)
                            begin
                                s_next = 1'b1;
                                s_tdata <= {4'b0000, st.data, st.idx};
                                s_tuser <= st.op;
                                sent++;
                                void'(stim_q.pop_front());
                            end
                        end
                    endcase
                end
                s_tvalid  <= s_next;
                cfg_valid <= c_next;
            end
        end
    end

    initial
    begin
        logic [3:0]  ord;
        int unsigned taps;
        int unsigned pick;
        order_reg = 4'd1;
        clear_history();
        foreach (num_coef[i])
        begin
            num_coef[i] = '0;
        end
        foreach (den_coef[i])
        begin
            den_coef[i] = '0;
        end

        add_xfer(iirdf1_pkg::OP_SAMPLE, 4'd5, 24'h123456);
        add_xfer(iirdf1_pkg::OP_WR_NUM, 4'd0, 24'h7FFFFF);
        add_xfer(iirdf1_pkg::OP_WR_NUM, 4'd1, 24'h800000);
        add_xfer(iirdf1_pkg::OP_WR_DEN, 4'd0, 24'h800000);
        add_xfer(iirdf1_pkg::OP_SAMPLE, 4'd0, 24'h7FFFFF);
        add_xfer(iirdf1_pkg::OP_SAMPLE, 4'd0, 24'h800000);
        add_xfer(iirdf1_pkg::OP_SAMPLE, 4'd0, 24'h000000);
        add_xfer(iirdf1_pkg::OP_WR_NUM, 4'd9, 24'h7FFFFF);
        add_xfer(iirdf1_pkg::OP_WR_NUM, 4'd15, 24'h555555);
        add_xfer(iirdf1_pkg::OP_WR_DEN, 4'd8, 24'h7FFFFF);
        add_xfer(iirdf1_pkg::OP_WR_DEN, 4'd15, 24'hAAAAAA);
        add_xfer(iirdf1_pkg::OP_SAMPLE, 4'd15, 24'h400000);
        add_xfer(iirdf1_pkg::OP_CLEAR, 4'd0, 24'hFFFFFF);
        add_xfer(iirdf1_pkg::OP_SAMPLE, 4'd0, 24'h000001);
        add_control(STEP_ORDER, 4'd8);
        add_xfer(iirdf1_pkg::OP_WR_NUM, 4'd8, 24'h100000);
        add_xfer(iirdf1_pkg::OP_WR_DEN, 4'd7, 24'h080000);
        for (int i = 0; i < 5; i++)
        begin
            add_xfer(iirdf1_pkg::OP_SAMPLE, 4'd0, 24'h200000 + 24'(i));
        end
        // The slot left at five must wrap once the order drops to three.
        add_control(STEP_ORDER, 4'd3);
        add_xfer(iirdf1_pkg::OP_SAMPLE, 4'd0, 24'h7FFFFF);
        add_control(STEP_ORDER, 4'd0);
        add_xfer(iirdf1_pkg::OP_SAMPLE, 4'd0, 24'h800001);
        add_control(STEP_ORDER, 4'd15);
        add_xfer(iirdf1_pkg::OP_SAMPLE, 4'd0, 24'h3FFFFF);

        while (n_items < ITEM_GOAL)
        begin
            case ($urandom_range(0, 5))
                0: ord = 4'd0;
                1: ord = 4'd8;
                2: ord = 4'd1;
                3: ord = 4'($urandom_range(9, 15));
                default: ord = 4'($urandom_range(1, 8));
            endcase
            add_control(STEP_ORDER, ord);
            taps = taps_in_use(ord);
            for (int i = 0; i <= taps; i++)
            begin
                add_xfer(iirdf1_pkg::OP_WR_NUM, 4'(i), rand_value());
            end
            for (int i = 0; i < taps; i++)
            begin
                add_xfer(iirdf1_pkg::OP_WR_DEN, 4'(i), rand_value());
            end
            if ($urandom_range(0, 1) != 0)
            begin
                add_xfer(iirdf1_pkg::OP_CLEAR, 4'($urandom()), 24'($urandom()));
            end
            repeat ($urandom_range(20, 80))
            begin
                pick = $urandom_range(0, 99);
                if (pick < 82)
                begin
                    add_xfer(iirdf1_pkg::OP_SAMPLE, 4'($urandom()),
                             pick < 40 ? 24'($urandom()) : rand_value());
                end
                else if (pick < 90)
                begin
                    add_xfer(pick < 86 ? iirdf1_pkg::OP_WR_NUM : iirdf1_pkg::OP_WR_DEN,
                             4'($urandom_range(0, 15)), rand_value());
                end
                else if (pick < 94)
                begin
                    add_xfer(iirdf1_pkg::OP_CLEAR, 4'($urandom()), 24'($urandom()));
                end
                else if (pick < 98)
                begin
                    add_xfer(2'($urandom()), 4'($urandom()), 24'($urandom()));
                end
                else
                begin
                    add_control(STEP_DRAIN, 4'd0);
                end
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (stim_q.size() != 0 || s_tvalid || cfg_valid)
        begin
            @(posedge clk);
        end
        while (expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/iirdf1_pkg.sv
sv/iirdf1_cell.sv
sv/iir_direct_form_one_filter.sv
verif/tb.sv
